// File: design/lbps_pkg.sv
// shared constants, pattern codes and types for the led and buzzer pattern sequencer
package lbps_pkg;

   localparam int PERIOD_BITS = 16;
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int PAT_W       = 4;
   localparam int STEP_W      = 3;
   localparam int PIN_W       = 3;
   localparam int NUM_PERIODS = 3;
   localparam int CNT_W       = $clog2(PERIOD_BITS + 1);

   // register indexes, also the lane numbers of the period set
   localparam logic [CSR_IDX_W-1:0] CSR_FAST      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERY_SLOW = 2'd2;

   localparam int LANE_FAST      = 0;
   localparam int LANE_SLOW      = 1;
   localparam int LANE_VERY_SLOW = 2;

   localparam logic [CFG_W-1:0] FAST_RESET      = 16'd10;
   localparam logic [CFG_W-1:0] SLOW_RESET      = 16'd25;
   localparam logic [CFG_W-1:0] VERY_SLOW_RESET = 16'd50;

   localparam logic [PAT_W-1:0] PAT_BUZZER       = 4'd0;
   localparam logic [PAT_W-1:0] PAT_ALL_LIT      = 4'd1;
   localparam logic [PAT_W-1:0] PAT_ALL_DARK     = 4'd2;
   localparam logic [PAT_W-1:0] PAT_CHASE_L_FAST = 4'd3;
   localparam logic [PAT_W-1:0] PAT_CHASE_L_SLOW = 4'd4;
   localparam logic [PAT_W-1:0] PAT_CHASE_R_FAST = 4'd5;
   localparam logic [PAT_W-1:0] PAT_CHASE_R_SLOW = 4'd6;
   localparam logic [PAT_W-1:0] PAT_BLUE         = 4'd7;
   localparam logic [PAT_W-1:0] PAT_YELLOW       = 4'd8;
   localparam logic [PAT_W-1:0] PAT_RED          = 4'd9;
   localparam logic [PAT_W-1:0] PAT_BLUE_SLOW    = 4'd10;
   localparam logic [PAT_W-1:0] PAT_YELLOW_SLOW  = 4'd11;
   localparam logic [PAT_W-1:0] PAT_RED_SLOW     = 4'd12;
   localparam logic [PAT_W-1:0] PAT_BLUE_FAST    = 4'd13;
   localparam logic [PAT_W-1:0] PAT_YELLOW_FAST  = 4'd14;
   localparam logic [PAT_W-1:0] PAT_RED_FAST     = 4'd15;

   localparam logic [PIN_W-1:0] PIN_BLUE   = 3'b001;
   localparam logic [PIN_W-1:0] PIN_YELLOW = 3'b010;
   localparam logic [PIN_W-1:0] PIN_RED    = 3'b100;
   localparam logic [PIN_W-1:0] PIN_ALL    = 3'b111;
   localparam logic [PIN_W-1:0] PIN_NONE   = 3'b000;

   localparam int PIN_YELLOW_BIT = 1;

   localparam logic [STEP_W-1:0] STEP_0 = 3'd0;
   localparam logic [STEP_W-1:0] STEP_1 = 3'd1;
   localparam logic [STEP_W-1:0] STEP_2 = 3'd2;
   localparam logic [STEP_W-1:0] STEP_3 = 3'd3;
   localparam logic [STEP_W-1:0] STEP_4 = 3'd4;
   localparam logic [STEP_W-1:0] STEP_5 = 3'd5;

   typedef logic [NUM_PERIODS-1:0][CFG_W-1:0] period_set_type;

   typedef struct packed {
      logic [NUM_PERIODS-1:0] valid;
      period_set_type         value;
   } rem_bus_type;

   // all pins switched on except the one colour that is lit
   function automatic logic [PIN_W-1:0] light_only(input logic [PIN_W-1:0] colour);
      return PIN_ALL & ~colour;
   endfunction

endpackage

// File: design/lbps_if.sv
// request and response channel interfaces of the sequencer
interface lbps_req_if;
   import lbps_pkg::*;

   logic             valid;
   logic             ready;
   logic             mode;
   logic [PAT_W-1:0] pattern;

   modport source (output valid, output mode, output pattern, input ready);
   modport sink   (input valid, input mode, input pattern, output ready);
endinterface

interface lbps_rsp_if;
   logic valid;
   logic ready;
   logic blue_pin;
   logic yellow_pin;
   logic red_pin;
   logic buzzer_high;

   modport source (output valid, output blue_pin, output yellow_pin, output red_pin,
                   output buzzer_high, input ready);
   modport sink   (input valid, input blue_pin, input yellow_pin, input red_pin,
                   input buzzer_high, output ready);
endinterface

// File: design/lbps_rem_unit.sv
// bit-serial remainder of the tick count by one period register
module lbps_rem_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lbps_pkg::PERIOD_BITS-1:0] dividend,
   input  logic [lbps_pkg::CFG_W-1:0]   divisor,
   output logic                         busy,
   output logic                         done,
   output logic [lbps_pkg::CFG_W-1:0]   rem
);
   import lbps_pkg::*;

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [PERIOD_BITS-1:0] div_ff, div_in;
   logic [CFG_W-1:0]       dsr_ff, dsr_in;
   logic [CFG_W-1:0]       rem_ff, rem_in;
   logic [CFG_W:0]         shifted;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, div_ff[PERIOD_BITS-1]};
      if (start) begin
         cnt_in = CNT_W'(PERIOD_BITS);
         div_in = dividend;
         // zero period behaves as a period of one
         dsr_in = (divisor == '0) ? CFG_W'(1) : divisor;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            shifted = shifted - {1'b0, dsr_ff};
         end
         rem_in  = shifted[CFG_W-1:0];
         div_in  = {div_ff[PERIOD_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign busy = (cnt_ff != '0) || done_ff;
   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// File: design/lbps_core.sv
// pattern state, tick and step counters, pin and buzzer levels
module lbps_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_accept,
   input  logic                             item_mode,
   input  logic [lbps_pkg::PAT_W-1:0]       item_pattern,
   input  lbps_pkg::period_set_type         periods,
   input  lbps_pkg::rem_bus_type            rem_bus,
   output logic [lbps_pkg::PERIOD_BITS-1:0] tick_count,
   output logic [lbps_pkg::PIN_W-1:0]       pin_levels,
   output logic                             buzzer_level
);
   import lbps_pkg::*;

   logic [PAT_W-1:0]       pat_ff, pat_in;
   logic [PERIOD_BITS-1:0] tick_ff, tick_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [PIN_W-1:0]       pins_ff, pins_in;
   logic                   buzz_ff, buzz_in;
   period_set_type         rem_ff, rem_in;

   logic [PERIOD_BITS-1:0] tick_inc;
   logic                   wrap;
   logic [CFG_W:0]         rem_inc [NUM_PERIODS];
   logic [CFG_W:0]         period_eff [NUM_PERIODS];
   period_set_type         rem_next;
   logic [NUM_PERIODS-1:0] hit;
   logic                   hit_sel;
   logic [STEP_W-1:0]      step_adv;

   always_comb begin
      tick_inc = tick_ff + PERIOD_BITS'(1);
      wrap     = (tick_inc == '0);
      // remainders of the tick count by each period, kept in step with it
      for (int k = 0; k < NUM_PERIODS; k++) begin
         period_eff[k] = (periods[k] == '0) ? (CFG_W+1)'(1) : {1'b0, periods[k]};
         rem_inc[k]    = {1'b0, rem_ff[k]} + (CFG_W+1)'(1);
         hit[k]        = wrap || (rem_inc[k] == period_eff[k]);
         rem_next[k]   = hit[k] ? '0 : rem_inc[k][CFG_W-1:0];
      end

      unique case (pat_ff) inside
         PAT_BUZZER: hit_sel = hit[LANE_VERY_SLOW];
         PAT_CHASE_L_FAST, PAT_CHASE_R_FAST, PAT_BLUE_FAST, PAT_YELLOW_FAST,
         PAT_RED_FAST: hit_sel = hit[LANE_FAST];
         PAT_CHASE_L_SLOW, PAT_CHASE_R_SLOW, PAT_BLUE_SLOW, PAT_YELLOW_SLOW,
         PAT_RED_SLOW: hit_sel = hit[LANE_SLOW];
         default: hit_sel = 1'b0;
      endcase
      step_adv = hit_sel ? step_ff + STEP_W'(1) : step_ff;

      pat_in  = pat_ff;
      tick_in = tick_ff;
      step_in = step_ff;
      pins_in = pins_ff;
      buzz_in = buzz_ff;
      rem_in  = rem_ff;

      for (int k = 0; k < NUM_PERIODS; k++) begin
         if (rem_bus.valid[k]) begin
            rem_in[k] = rem_bus.value[k];
         end
      end

      if (item_accept) begin
         if (item_mode) begin
            if (item_pattern != pat_ff) begin
               pat_in  = item_pattern;
               tick_in = '0;
               step_in = '0;
               buzz_in = 1'b0;
               pins_in = PIN_ALL;
               rem_in  = '0;
            end
         end else begin
            tick_in = tick_inc;
            rem_in  = rem_next;
            unique case (pat_ff)
               PAT_BUZZER: begin
                  step_in = step_adv;
                  case (step_adv) inside
                     STEP_1, STEP_3: begin
                        buzz_in = 1'b1;
                        pins_in[PIN_YELLOW_BIT] = 1'b0;
                     end
                     STEP_2, STEP_4: begin
                        buzz_in = 1'b0;
                        pins_in[PIN_YELLOW_BIT] = 1'b1;
                     end
                     STEP_5: step_in = STEP_1;
                     default: ;
                  endcase
               end
               PAT_ALL_LIT:  pins_in = PIN_NONE;
               PAT_ALL_DARK: pins_in = PIN_ALL;
               PAT_CHASE_L_FAST, PAT_CHASE_L_SLOW, PAT_CHASE_R_FAST, PAT_CHASE_R_SLOW: begin
                  step_in = step_adv;
                  case (step_adv)
                     STEP_1: pins_in = light_only(
                        (pat_ff == PAT_CHASE_R_FAST || pat_ff == PAT_CHASE_R_SLOW) ?
                        PIN_RED : PIN_BLUE);
                     STEP_2: pins_in = light_only(PIN_YELLOW);
                     STEP_3: pins_in = light_only(
                        (pat_ff == PAT_CHASE_R_FAST || pat_ff == PAT_CHASE_R_SLOW) ?
                        PIN_BLUE : PIN_RED);
                     STEP_4: step_in = STEP_1;
                     default: ;
                  endcase
               end
               PAT_BLUE:   pins_in = light_only(PIN_BLUE);
               PAT_YELLOW: pins_in = light_only(PIN_YELLOW);
               PAT_RED:    pins_in = light_only(PIN_RED);
               default: begin
                  // blink patterns: lit for the one tick that lands on a period
                  if (step_adv != STEP_0) begin
                     step_in = STEP_0;
                     case (pat_ff) inside
                        PAT_BLUE_SLOW, PAT_BLUE_FAST:     pins_in = light_only(PIN_BLUE);
                        PAT_YELLOW_SLOW, PAT_YELLOW_FAST: pins_in = light_only(PIN_YELLOW);
                        default:                          pins_in = light_only(PIN_RED);
                     endcase
                  end else begin
                     step_in = step_adv;
                     pins_in = PIN_ALL;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= PAT_ALL_DARK;
         tick_ff <= '0;
         step_ff <= '0;
         pins_ff <= PIN_ALL;
         buzz_ff <= 1'b0;
         rem_ff  <= '0;
      end else begin
         pat_ff  <= pat_in;
         tick_ff <= tick_in;
         step_ff <= step_in;
         pins_ff <= pins_in;
         buzz_ff <= buzz_in;
         rem_ff  <= rem_in;
      end
   end

   assign tick_count   = tick_ff;
   assign pin_levels   = pins_ff;
   assign buzzer_level = buzz_ff;

endmodule

// File: design/led_buzzer_pattern_sequencer.sv
// top level of the led and buzzer pattern sequencer
// Takes one word per cycle when not held off, a tick or a pattern select, and answers
// each with one word holding the three LED pin levels and the buzzer level after it;
// the pin and buzzer registers are the result register, so a new word is taken in the
// cycle the previous result is taken. Period checks use per-period remainder counters
// that run alongside the tick counter. After each csr write the block holds off new
// words while three bit-serial remainder units realign those counters to the new
// periods.
module led_buzzer_pattern_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   lbps_req_if.sink                       req_chan,
   lbps_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [lbps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lbps_pkg::CFG_W-1:0]     csr_wdata
);
   import lbps_pkg::*;

   period_set_type         period_ff, period_in;
   logic                   start_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUM_PERIODS-1:0] unit_busy;
   rem_bus_type            rem_bus;
   logic                   busy;
   logic                   accept;
   logic [PERIOD_BITS-1:0] tick_count;
   logic [PIN_W-1:0]       pin_levels;
   logic                   buzzer_level;

   always_comb begin
      period_in = period_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FAST:      period_in[LANE_FAST]      = csr_wdata;
            CSR_SLOW:      period_in[LANE_SLOW]      = csr_wdata;
            CSR_VERY_SLOW: period_in[LANE_VERY_SLOW] = csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy           = start_ff || (|unit_busy);
   assign req_chan.ready = !busy && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff[LANE_FAST]      <= FAST_RESET;
         period_ff[LANE_SLOW]      <= SLOW_RESET;
         period_ff[LANE_VERY_SLOW] <= VERY_SLOW_RESET;
         start_ff                  <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         period_ff    <= period_in;
         start_ff     <= csr_we;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar k = 0; k < NUM_PERIODS; k++) begin : g_rem
      lbps_rem_unit u_rem (
         .clock    (clock),
         .reset    (reset),
         .start    (start_ff),
         .dividend (tick_count),
         .divisor  (period_ff[k]),
         .busy     (unit_busy[k]),
         .done     (rem_bus.valid[k]),
         .rem      (rem_bus.value[k])
      );
   end

   lbps_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (accept),
      .item_mode    (req_chan.mode),
      .item_pattern (req_chan.pattern),
      .periods      (period_ff),
      .rem_bus      (rem_bus),
      .tick_count   (tick_count),
      .pin_levels   (pin_levels),
      .buzzer_level (buzzer_level)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.blue_pin    = pin_levels[0];
   assign rsp_chan.yellow_pin  = pin_levels[PIN_YELLOW_BIT];
   assign rsp_chan.red_pin     = pin_levels[2];
   assign rsp_chan.buzzer_high = buzzer_level;

endmodule

// File: verif/led_buzzer_pattern_sequencer_test.sv
// self-checking testbench for the led and buzzer pattern sequencer
module led_buzzer_pattern_sequencer_test;
   import lbps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [CFG_W-1:0]     PERIOD_MAX = 16'hFFFF;
   localparam logic [CFG_W-1:0]     LONG_PERIOD = 16'd97;
   localparam int                   MAX_GAP = 5;
   localparam int                   RANDOM_WORDS = 1200;
   localparam int                   LONG_TICKS = 200;

   typedef struct packed {
      logic blue;
      logic yellow;
      logic red;
      logic buzzer;
   } pin_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   lbps_req_if req_chan ();
   lbps_rsp_if rsp_chan ();

   led_buzzer_pattern_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted display state
   logic [CFG_W-1:0]       fast_ticks;
   logic [CFG_W-1:0]       slow_ticks;
   logic [CFG_W-1:0]       very_slow_ticks;
   logic [PAT_W-1:0]       shown_pattern;
   logic [PERIOD_BITS-1:0] tick_total;
   logic [STEP_W-1:0]      step_idx;
   logic [PIN_W-1:0]       pin_state;
   logic                   buzz_state;

   pin_word_type expected_pins[$];
   int           fault_count = 0;
   bit           gaps_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [PIN_W-1:0] lit_one(input logic [PIN_W-1:0] colour);
      return PIN_ALL & ~colour;
   endfunction

   function automatic void bump_step(input logic [CFG_W-1:0] period);
      int unsigned p;
      p = (period == '0) ? 1 : period;
      if ((tick_total % p) == 0) step_idx = step_idx + 1'b1;
   endfunction

   function automatic void chase_step(input logic [CFG_W-1:0] period, input logic rightward);
      bump_step(period);
      case (step_idx)
         STEP_1: pin_state = lit_one(rightward ? PIN_RED : PIN_BLUE);
         STEP_2: pin_state = lit_one(PIN_YELLOW);
         STEP_3: pin_state = lit_one(rightward ? PIN_BLUE : PIN_RED);
         STEP_4: step_idx = STEP_1;
         default: ;
      endcase
   endfunction

   function automatic void blink_step(input logic [CFG_W-1:0] period,
                                      input logic [PIN_W-1:0] colour);
      bump_step(period);
      if (step_idx != STEP_0) begin
         pin_state = lit_one(colour);
         step_idx  = STEP_0;
      end else begin
         pin_state = PIN_ALL;
      end
   endfunction

   function automatic void buzz_step();
      bump_step(very_slow_ticks);
      case (step_idx)
         STEP_1, STEP_3: begin
            buzz_state = 1'b1;
            pin_state  = pin_state & ~PIN_YELLOW;
         end
         STEP_2, STEP_4: begin
            buzz_state = 1'b0;
            pin_state  = pin_state | PIN_YELLOW;
         end
         STEP_5: step_idx = STEP_1;
         default: ;
      endcase
   endfunction

   function automatic pin_word_type advance_display(input logic m,
                                                    input logic [PAT_W-1:0] p);
      pin_word_type w;
      if (m) begin
         if (p != shown_pattern) begin
            tick_total    = '0;
            step_idx      = STEP_0;
            buzz_state    = 1'b0;
            pin_state     = PIN_ALL;
            shown_pattern = p;
         end
      end else begin
         tick_total = tick_total + 1'b1;
         case (shown_pattern)
            PAT_BUZZER:       buzz_step();
            PAT_ALL_LIT:      pin_state = PIN_NONE;
            PAT_ALL_DARK:     pin_state = PIN_ALL;
            PAT_CHASE_L_FAST: chase_step(fast_ticks, 1'b0);
            PAT_CHASE_L_SLOW: chase_step(slow_ticks, 1'b0);
            PAT_CHASE_R_FAST: chase_step(fast_ticks, 1'b1);
            PAT_CHASE_R_SLOW: chase_step(slow_ticks, 1'b1);
            PAT_BLUE:         pin_state = lit_one(PIN_BLUE);
            PAT_YELLOW:       pin_state = lit_one(PIN_YELLOW);
            PAT_RED:          pin_state = lit_one(PIN_RED);
            PAT_BLUE_SLOW:    blink_step(slow_ticks, PIN_BLUE);
            PAT_YELLOW_SLOW:  blink_step(slow_ticks, PIN_YELLOW);
            PAT_RED_SLOW:     blink_step(slow_ticks, PIN_RED);
            PAT_BLUE_FAST:    blink_step(fast_ticks, PIN_BLUE);
            PAT_YELLOW_FAST:  blink_step(fast_ticks, PIN_YELLOW);
            default:          blink_step(fast_ticks, PIN_RED);
         endcase
      end
      w.blue   = (pin_state & PIN_BLUE) != PIN_NONE;
      w.yellow = (pin_state & PIN_YELLOW) != PIN_NONE;
      w.red    = (pin_state & PIN_RED) != PIN_NONE;
      w.buzzer = buzz_state;
      return w;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance with valid still high
   task automatic send_word(input logic m, input logic [PAT_W-1:0] p);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.mode    = m;
      req_chan.pattern = p;
      do @(posedge clock); while (!req_chan.ready);
      expected_pins.push_back(advance_display(m, p));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (expected_pins.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_FAST:      fast_ticks = val;
         CSR_SLOW:      slow_ticks = val;
         CSR_VERY_SLOW: very_slow_ticks = val;
         default: ;
      endcase
   endtask

   // result checker and sink stall
   initial begin
      pin_word_type got;
      pin_word_type want;
      int stall;
      stall = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.blue   = rsp_chan.blue_pin;
            got.yellow = rsp_chan.yellow_pin;
            got.red    = rsp_chan.red_pin;
            got.buzzer = rsp_chan.buzzer_high;
            if (expected_pins.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected word: blue %0b yellow %0b red %0b buzzer %0b",
                           got.blue, got.yellow, got.red, got.buzzer);
            end else begin
               want = expected_pins.pop_front();
               if (got.blue !== want.blue || got.yellow !== want.yellow ||
                   got.red !== want.red || got.buzzer !== want.buzzer) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch: exp b%0b y%0b r%0b z%0b, got b%0b y%0b r%0b z%0b",
                              want.blue, want.yellow, want.red, want.buzzer,
                              got.blue, got.yellow, got.red, got.buzzer);
               end
            end
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            stall--;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   task automatic test_reset_values();
      send_word(1'b0, PAT_RED_FAST);
      // selecting the current pattern changes nothing
      send_word(1'b1, PAT_ALL_DARK);
      send_word(1'b0, PAT_BUZZER);
      wait_idle();
   endtask

   task automatic test_every_pattern();
      // zero period steps every tick, spare index is ignored
      write_csr(CSR_SPARE, PERIOD_MAX);
      write_csr(CSR_FAST, 16'd0);
      write_csr(CSR_SLOW, 16'd2);
      write_csr(CSR_VERY_SLOW, 16'd1);
      for (int p = 0; p < 16; p++) begin
         send_word(1'b1, p[PAT_W-1:0]);
         send_word(1'b0, ~p[PAT_W-1:0]);
      end
      send_word(1'b1, PAT_RED_FAST);
      send_word(1'b0, PAT_RED_FAST);
      wait_idle();
   endtask

   task automatic test_long_periods();
      gaps_on = 1'b0;
      write_csr(CSR_FAST, PERIOD_MAX);
      write_csr(CSR_SLOW, LONG_PERIOD);
      write_csr(CSR_VERY_SLOW, PERIOD_MAX);
      // a long slow chase, fast and buzzer periods never come round
      send_word(1'b1, PAT_CHASE_R_SLOW);
      repeat (LONG_TICKS) send_word(1'b0, PAT_BUZZER);
      wait_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_sequences();
      int sent;
      int run;
      int pick;
      logic [PAT_W-1:0] pat;
      logic [CFG_W-1:0] val;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         wait_idle();
         gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < NUM_PERIODS; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)       val = CFG_W'($urandom_range(1, 6));
            else if (pick == 7) val = '0;
            else if (pick == 8) val = PERIOD_MAX;
            else                val = CFG_W'($urandom_range(0, 65535));
            write_csr(i[CSR_IDX_W-1:0], val);
         end
         if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, CFG_W'($urandom_range(0, 65535)));
         repeat ($urandom_range(4, 10)) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               // select then a run of ticks, now and then the same select again
               pat = PAT_W'($urandom_range(0, 15));
               send_word(1'b1, pat);
               sent++;
               run = $urandom_range(1, 40);
               repeat (run) begin
                  if ($urandom_range(0, 19) == 0) send_word(1'b1, pat);
                  else send_word(1'b0, PAT_W'($urandom_range(0, 15)));
                  sent++;
               end
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  send_word(1'($urandom_range(0, 1)), PAT_W'($urandom_range(0, 15)));
                  sent++;
               end
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      int waited;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.mode    = 1'b0;
      req_chan.pattern = '0;
      fast_ticks       = FAST_RESET;
      slow_ticks       = SLOW_RESET;
      very_slow_ticks  = VERY_SLOW_RESET;
      shown_pattern    = PAT_ALL_DARK;
      tick_total       = '0;
      step_idx         = STEP_0;
      pin_state        = PIN_ALL;
      buzz_state       = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_every_pattern();
      test_long_periods();
      test_random_sequences();

      req_chan.valid = 1'b0;
      waited = 0;
      while (expected_pins.size() != 0 && waited < 1000) begin
         @(negedge clock);
         waited++;
      end
      repeat (PERIOD_BITS + 4) @(negedge clock);
      if (expected_pins.size() != 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0d expected words never arrived", expected_pins.size());
      end
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
design/lbps_pkg.sv
design/lbps_if.sv
design/lbps_rem_unit.sv
design/lbps_core.sv
design/led_buzzer_pattern_sequencer.sv
verif/led_buzzer_pattern_sequencer_test.sv
